// ===== rtl/core/aca_pkg.sv =====
// ----------------------------------------------------------------------------
// aca_pkg
// Shared types and constants for the address claim arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package aca_pkg;

  localparam int POOL_SIZE   = 8;
  localparam int POOL_IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int ADDR_W      = 8;
  localparam int NAME_W      = 64;
  localparam int DELAY_W     = 5;
  localparam int ACT_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 16;

  localparam logic [ADDR_W-1:0]  POOL_BASE         = 8'd128;
  localparam logic [ADDR_W-1:0]  EXHAUSTED_ADDRESS = 8'd247;
  localparam logic [DELAY_W-1:0] DELAY_DEFAULT     = 5'd31;

  // Input kinds
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLAIM   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NAME        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAIM_DELAY     = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic scan_step;
    logic load_out;
  } aca_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } aca_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/aca_dp.sv =====
// ----------------------------------------------------------------------------
// aca_dp
// Datapath: config registers, address state, countdown, pool occupancy bits,
// pool scan counter and output data register.
// ----------------------------------------------------------------------------
`default_nettype none

module aca_dp
  import aca_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [NAME_W-1:0]     cfg_wdata_i,
  input  wire logic [ACT_W-1:0]      act_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire aca_cmd_t              cmd_i,
  output aca_sts_t                   sts_o,
  output logic [OUT_DATA_W-1:0]      out_data_o
);

  logic [ADDR_W-1:0]     init_addr_q;
  logic [NAME_W-1:0]     own_name_q;
  logic [DELAY_W-1:0]    claim_delay_q;

  logic [ACT_W-1:0]      act_q;
  logic [ADDR_W-1:0]     src_q;
  logic [NAME_W-1:0]     pname_q;

  logic [ADDR_W-1:0]     our_q, our_d;
  logic [ADDR_W-1:0]     prev_q, prev_d;
  logic [DELAY_W-1:0]    cd_q, cd_d;
  logic [POOL_SIZE-1:0]  taken_q, taken_d;
  logic [POOL_IDX_W-1:0] idx_q, idx_d;
  logic                  send_q, send_d;
  logic                  save_q, save_d;
  logic                  settled_q, settled_d;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [DELAY_W-1:0]    eff_delay;
  logic                  collide;
  logic                  name_le;
  logic                  need_scan;
  logic [ADDR_W-1:0]     scan_addr;
  logic                  scan_found;
  logic                  scan_last;

  assign eff_delay  = (claim_delay_q == '0) ? DELAY_DEFAULT : claim_delay_q;
  assign collide    = (act_q == ACT_CLAIM) && (src_q == our_q);
  assign name_le    = (pname_q <= own_name_q);
  assign need_scan  = collide && (name_le || (cd_q != '0));
  assign scan_addr  = POOL_BASE + ADDR_W'(idx_q);
  // the colliding entry is marked taken but never chosen
  assign scan_found = (scan_addr != src_q) && !taken_q[idx_q];
  assign scan_last  = (idx_q == POOL_IDX_W'(POOL_SIZE - 1));

  assign sts_o.need_scan = need_scan;
  assign sts_o.scan_done = scan_found || scan_last;
  assign out_data_o      = out_data_q;

  always_comb begin
    our_d     = our_q;
    prev_d    = prev_q;
    cd_d      = cd_q;
    taken_d   = taken_q;
    idx_d     = idx_q;
    send_d    = send_q;
    save_d    = save_q;
    settled_d = settled_q;

    if (cmd_i.exec) begin
      send_d    = 1'b0;
      save_d    = 1'b0;
      settled_d = 1'b0;
      idx_d     = '0;
      case (act_q)
        ACT_RESTART: begin
          for (int i = 0; i < POOL_SIZE; i++) begin
            taken_d[i] = (ADDR_W'(POOL_BASE + ADDR_W'(i)) == init_addr_q);
          end
          our_d  = init_addr_q;
          prev_d = init_addr_q;
          cd_d   = eff_delay;
        end
        ACT_CLAIM: begin
          if (need_scan) begin
            prev_d = our_q;
            if (name_le) begin
              cd_d = eff_delay;
            end
          end else if (collide) begin
            send_d = 1'b1;
          end
        end
        ACT_TICK: begin
          if (cd_q != '0) begin
            cd_d = cd_q - 1'b1;
            if (cd_q == DELAY_W'(1)) begin
              send_d = 1'b1;
              save_d = (our_q != prev_q);
            end
          end
          settled_d = (cd_q == '0) || (cd_q == DELAY_W'(1));
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.scan_step) begin
      if (scan_addr == src_q) begin
        taken_d[idx_q] = 1'b1;
      end
      if (scan_found) begin
        taken_d[idx_q] = 1'b1;
        our_d          = scan_addr;
      end else if (scan_last) begin
        our_d = EXHAUSTED_ADDRESS;
      end
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_addr_q   <= POOL_BASE;
      own_name_q    <= '0;
      claim_delay_q <= DELAY_DEFAULT;
      our_q         <= '0;
      prev_q        <= '0;
      cd_q          <= '0;
      taken_q       <= '0;
      idx_q         <= '0;
      send_q        <= 1'b0;
      save_q        <= 1'b0;
      settled_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INITIAL_ADDRESS: init_addr_q   <= cfg_wdata_i[ADDR_W-1:0];
          CFG_OWN_NAME:        own_name_q    <= cfg_wdata_i;
          CFG_CLAIM_DELAY:     claim_delay_q <= cfg_wdata_i[DELAY_W-1:0];
          default: begin
          end
        endcase
      end
      our_q     <= our_d;
      prev_q    <= prev_d;
      cd_q      <= cd_d;
      taken_q   <= taken_d;
      idx_q     <= idx_d;
      send_q    <= send_d;
      save_q    <= save_d;
      settled_q <= settled_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q   <= act_i;
      src_q   <= in_data_i[ADDR_W-1:0];
      pname_q <= in_data_i[ADDR_W +: NAME_W];
    end
    if (cmd_i.load_out) begin
      out_data_q <= {5'b0, settled_q, save_q, send_q, our_q};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/aca_ctrl.sv =====
// ----------------------------------------------------------------------------
// aca_ctrl
// Controller: sequences accept, evaluate, pool scan and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module aca_ctrl
  import aca_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire aca_sts_t sts_i,
  output aca_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load_in   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.exec      = (state_q == ST_EXEC);
  assign cmd_o.scan_step = (state_q == ST_SCAN);
  assign cmd_o.load_out  = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= sts_i.need_scan ? ST_SCAN : ST_DONE;
        end
        ST_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/address_claim_arbiter.sv =====
// Flow: an input beat is accepted, evaluated, and its result loaded into the
//   output register; a collision that forces a move adds a pool scan, one pool
//   entry scanned per cycle. Only one item is in flight: a new input beat is
//   accepted only after the previous result has been loaded for output.
// Reset: asynchronous, active low; addresses and countdown zero, pool free,
//   config registers at their defaults. No clearing pass.
// ----------------------------------------------------------------------------
// address_claim_arbiter
// Address claim arbitration with an occupancy-tracked address pool.
// ----------------------------------------------------------------------------
`default_nettype none

module address_claim_arbiter
  import aca_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [NAME_W-1:0]     cfg_wdata_i,
  // input beats
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // peer_source[7:0], sender_name[71:8]
  input  wire logic [ACT_W-1:0]      s_axis_tuser_i,  // action[1:0]
  // result beats
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o   // current_address[7:0], send_claim[8],
                                                      // save_address[9], claim_settled[10]
);

  aca_cmd_t cmd;
  aca_sts_t sts;

  aca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  aca_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .act_i       (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/aca_checker.sv =====
// ----------------------------------------------------------------------------
// aca_checker
// Port-level checks for the address claim arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aca_checker
  import aca_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // a save only happens together with a settling claim
  a_save_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[9] |-> m_axis_tdata_o[8] && m_axis_tdata_o[10])
    else $error("save_address without send_claim and claim_settled");

  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is in flight");

  // a result cannot appear right after an accept
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result valid too early");

endmodule

bind address_claim_arbiter aca_checker u_aca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
